[src/sha256_pkg.sv]
// SHA-256 stream hasher package: opcodes, round constants, initial hash values
// and round helper functions. No dependencies.
`default_nettype none
package sha256_pkg;

    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    typedef logic [7:0][31:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [63:0][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_value;
        logic       count_bits;
        logic       load_len;
        logic       round_start;
        logic       round_step;
        logic       round_fold;
        logic       reinit;
        logic       shift_out;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

[src/sha256_if.sv]
// Valid/ready stream interfaces for the request and digest channels.
// No dependencies.
`default_nettype none
interface sha256_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface
`default_nettype wire

[src/sha256_stream_hasher_unit.sv]
// SHA-256 stream hasher top level: controller plus datapath.
// Absorb and restart are accepted in S_IDLE; a block that fills runs 64 rounds, then a fold.
// Finish pads one byte a cycle to fill the block, runs one or two compressions,
// then sends 8 digest words, one per cycle when taken.
// Reset (rst_n low, asynchronous) loads the initial hash and clears counts.
`default_nettype none
module sha256_stream_hasher_unit (
    input  wire           clk,
    input  wire           rst_n,
    sha256_req_if.sink    req,
    sha256_out_if.source  dout
);

    sha256_pkg::sha_cmd_t  cmd;
    sha256_pkg::sha_stat_t stat;
    logic [31:0]           head_word;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .dout      (dout),
        .stat      (stat),
        .head_word (head_word),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .head_word (head_word)
    );

endmodule
`default_nettype wire

[src/sha256_datapath.sv]
// SHA-256 datapath: message schedule window (also collects the incoming block),
// round registers, hash words and bit counter. Depends on sha256_pkg.
`default_nettype none
module sha256_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha256_pkg::sha_cmd_t  cmd,
    output sha256_pkg::sha_stat_t stat,
    output logic [31:0]           head_word
);

    logic [5:0]              fill_reg, fill_next;
    logic [63:0]             bits_reg, bits_next;
    logic [15:0][31:0]       w_reg;
    sha256_pkg::hash_t       v_reg;
    sha256_pkg::hash_t       h_reg, h_next;
    logic [5:0]              rnd_reg;
    logic [31:0]             t1, t2, w_new, e, a;
    logic [3:0]              wsel;
    logic [1:0]              bsel;
    logic [7:0]              load_val;

    assign wsel = ~fill_reg[5:2];
    assign bsel = ~fill_reg[1:0];
    assign load_val = cmd.load_len ? bits_reg[{~fill_reg[2:0], 3'b000} +: 8] : cmd.byte_value;

    assign e = v_reg[3];
    assign a = v_reg[7];
    assign t1 = v_reg[0] + sha256_pkg::bsig1(e) + ((e & v_reg[2]) ^ (~e & v_reg[1]))
              + sha256_pkg::ROUND_K[63 - rnd_reg] + w_reg[15];
    assign t2 = sha256_pkg::bsig0(a) + ((a & v_reg[6]) ^ (a & v_reg[5]) ^ (v_reg[6] & v_reg[5]));
    assign w_new = sha256_pkg::sig1(w_reg[1]) + w_reg[6] + sha256_pkg::sig0(w_reg[14])
                 + w_reg[15];

    always_comb
    begin
        fill_next = fill_reg;
        bits_next = bits_reg;
        h_next = h_reg;
        if (cmd.load_byte || cmd.load_len)
            fill_next = fill_reg + 6'd1;
        if (cmd.count_bits)
            bits_next = bits_reg + 64'd8;
        if (cmd.round_fold)
        begin
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        end
        if (cmd.shift_out)
            h_next = {h_reg[6:0], 32'd0};
        if (cmd.reinit)
        begin
            h_next = sha256_pkg::INIT_HASH;
            bits_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
            h_reg <= sha256_pkg::INIT_HASH;
            rnd_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            h_reg <= h_next;
            if (cmd.round_start)
                rnd_reg <= '0;
            else if (cmd.round_step)
                rnd_reg <= rnd_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.load_len)
            w_reg[wsel][{bsel, 3'b000} +: 8] <= load_val;
        else if (cmd.round_step)
            w_reg <= {w_reg[14:0], w_new};
        if (cmd.round_start)
            v_reg <= h_reg;
        else if (cmd.round_step)
            v_reg <= {t1 + t2, v_reg[7:5], v_reg[4] + t1, v_reg[3:1]};
    end

    assign stat.fill = fill_reg;
    assign stat.round_last = (rnd_reg == 6'd63);
    assign head_word = h_reg[7];

endmodule
`default_nettype wire

[src/sha256_ctrl.sv]
// SHA-256 controller: request handshake, padding sequence, round control
// and digest output. Depends on sha256_pkg and sha256_if.
`default_nettype none
module sha256_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    sha256_req_if.sink            req,
    sha256_out_if.source          dout,
    input  sha256_pkg::sha_stat_t stat,
    input  wire [31:0]            head_word,
    output sha256_pkg::sha_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_ROUND, S_FOLD, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       dv_reg, dv_next;
    logic [2:0] idx_reg, idx_next;
    logic       acc;

    assign req.ready = (state_reg == S_IDLE);
    assign acc = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        dv_next = dv_reg;
        idx_next = idx_reg;
        cmd = '0;
        cmd.byte_value = req.data_byte;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.opcode)
                        sha256_pkg::OP_ABSORB:
                        begin
                            cmd.load_byte = 1'b1;
                            cmd.count_bits = 1'b1;
                            fin_next = 1'b0;
                            if (stat.fill == 6'd63)
                                state_next = S_ROUND;
                        end
                        sha256_pkg::OP_FINISH:
                        begin
                            cmd.load_byte = 1'b1;
                            cmd.byte_value = sha256_pkg::PAD_BYTE;
                            fin_next = 1'b1;
                            if (stat.fill == 6'd63)
                                state_next = S_ROUND;
                            else if (stat.fill == sha256_pkg::LEN_OFFSET - 6'd1)
                                state_next = S_LEN;
                            else
                                state_next = S_PAD;
                        end
                        sha256_pkg::OP_RESTART: cmd.reinit = 1'b1;
                        default: ;
                    endcase
                    cmd.round_start = 1'b1;
                end
            end
            S_PAD:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_value = 8'd0;
                if (stat.fill == 6'd63)
                    state_next = S_ROUND;
                else if (stat.fill == sha256_pkg::LEN_OFFSET - 6'd1 && fin_reg)
                    state_next = S_LEN;
                cmd.round_start = 1'b1;
            end
            S_LEN:
            begin
                cmd.load_len = 1'b1;
                fin_next = 1'b0;
                dv_next = 1'b0;
                if (stat.fill == 6'd63)
                    state_next = S_ROUND;
                cmd.round_start = 1'b1;
                fin_next = 1'b1;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.round_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.round_fold = 1'b1;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (stat.fill == 6'd0 && dv_reg)
                begin
                    state_next = S_PAD;
                    dv_next = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                    idx_next = '0;
                end
            end
            S_OUT:
            begin
                if (dout.ready)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reinit = 1'b1;
                        fin_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && acc && req.opcode == sha256_pkg::OP_FINISH)
            dv_next = (stat.fill >= sha256_pkg::LEN_OFFSET);
        if (state_reg == S_PAD && dv_reg)
            dv_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg <= 1'b0;
            dv_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            dv_reg <= dv_next;
            idx_reg <= idx_next;
        end
    end

    assign dout.valid = (state_reg == S_OUT);
    assign dout.digest_word = head_word;
    assign dout.word_index = idx_reg;
    assign dout.last_word = (idx_reg == 3'd7);

endmodule
`default_nettype wire

[bench/tb_sha256_stream_hasher_unit.sv]
// Testbench for sha256_stream_hasher_unit: drives absorb/finish/restart requests,
// predicts digests with its own SHA-256 model and checks every digest word.
// Depends on sha256_pkg and the interfaces in sha256_if.sv.
`default_nettype none
module tb_sha256_stream_hasher_unit;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } request_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    sha256_req_if req ();
    sha256_out_if dout ();

    sha256_stream_hasher_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .dout  (dout)
    );

    request_t      pending_requests[$];
    digest_item_t  expected_digest_words[$];
    logic [31:0]   chain_hash[8];
    logic [7:0]    msg_block[64];
    int unsigned   block_fill;
    logic [63:0]   msg_bit_total;
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   hold_off_cycles;
    bit            no_idle;
    bit            stimulus_done;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] s0;
        logic [31:0] s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_hash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[63 - i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_hash[i] = chain_hash[i] + v[i];
    endtask

    task automatic reinit_hash();
        for (int i = 0; i < 8; i++)
            chain_hash[i] = sha256_pkg::INIT_HASH[7 - i];
        block_fill = 0;
        msg_bit_total = '0;
    endtask

    task automatic predict_request(input request_t r);
        digest_item_t d;
        case (r.opcode)
            sha256_pkg::OP_ABSORB:
            begin
                msg_block[block_fill] = r.data_byte;
                msg_bit_total = msg_bit_total + 64'd8;
                block_fill++;
                if (block_fill == 64)
                begin
                    compress_msg_block();
                    block_fill = 0;
                end
            end
            sha256_pkg::OP_RESTART: reinit_hash();
            sha256_pkg::OP_FINISH:
            begin
                msg_block[block_fill] = sha256_pkg::PAD_BYTE;
                block_fill++;
                if (block_fill > sha256_pkg::LEN_OFFSET)
                begin
                    while (block_fill < 64)
                        msg_block[block_fill++] = 8'h00;
                    compress_msg_block();
                    block_fill = 0;
                end
                while (block_fill < sha256_pkg::LEN_OFFSET)
                    msg_block[block_fill++] = 8'h00;
                for (int i = 0; i < 8; i++)
                    msg_block[sha256_pkg::LEN_OFFSET + i] = msg_bit_total[63 - 8*i -: 8];
                compress_msg_block();
                for (int i = 0; i < 8; i++)
                begin
                    d.digest_word = chain_hash[i];
                    d.word_index = 3'(i);
                    d.last_word = (i == 7);
                    expected_digest_words.push_back(d);
                end
                reinit_hash();
            end
            default: ;
        endcase
    endtask

    function automatic request_t make_req(input logic [1:0] op, input logic [7:0] b);
        request_t r;
        r.opcode = op;
        r.data_byte = b;
        return r;
    endfunction

    task automatic add_message(input int unsigned len, input bit all_ones);
        for (int unsigned i = 0; i < len; i++)
            pending_requests.push_back(make_req(sha256_pkg::OP_ABSORB,
                all_ones ? 8'hff : 8'($urandom_range(0, 255))));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sha256_stream_hasher_unit NOT OK");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.opcode <= sha256_pkg::OP_ABSORB;
            req.data_byte <= 8'h00;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_request(pending_requests.pop_front());
            end
            if ((!req.valid || req.ready) && pending_requests.size() > 0
                && (no_idle || $urandom_range(0, 99) >= 37))
            begin
                req.valid <= 1'b1;
                req.opcode <= pending_requests[0].opcode;
                req.data_byte <= pending_requests[0].data_byte;
            end
            else if (req.ready)
                req.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            dout.ready <= 1'b0;
        end
        else
            dout.ready <= no_idle || $urandom_range(0, 99) >= 37;
    end

    always @(posedge clk)
    begin
        digest_item_t got;
        digest_item_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            got.digest_word = dout.digest_word;
            got.word_index = dout.word_index;
            got.last_word = dout.last_word;
            if (expected_digest_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest word %h idx %0d last %0b",
                             got.digest_word, got.word_index, got.last_word);
            end
            else
            begin
                want = expected_digest_words.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 want.digest_word, want.word_index, want.last_word,
                                 got.digest_word, got.word_index, got.last_word);
                end
            end
        end
    end

    initial
    begin
        int unsigned len;
        int unsigned pick;
        cycle_count = 0;
        mismatch_count = 0;
        hold_off_cycles = 0;
        no_idle = 1'b0;
        stimulus_done = 1'b0;
        reinit_hash();
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        @(posedge rst_n);

        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        pending_requests.push_back(make_req(OP_UNUSED, 8'hff));
        add_message(3, 1'b0);
        pending_requests.push_back(make_req(sha256_pkg::OP_ABSORB, 8'h00));
        pending_requests.push_back(make_req(sha256_pkg::OP_ABSORB, 8'hff));
        pending_requests.push_back(make_req(sha256_pkg::OP_RESTART, 8'ha5));
        pending_requests.push_back(make_req(sha256_pkg::OP_ABSORB, 8'h5a));
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'hff));
        add_message(55, 1'b1);
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        add_message(56, 1'b0);
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        add_message(64, 1'b0);
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        wait (pending_requests.size() == 0 && expected_digest_words.size() == 0);

        hold_off_cycles = 400;
        add_message(40, 1'b0);
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        wait (pending_requests.size() == 0 && expected_digest_words.size() == 0);

        no_idle = 1'b1;
        add_message(70, 1'b0);
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        wait (pending_requests.size() == 0);
        no_idle = 1'b0;

        for (int n = 0; n < 160; )
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130)
                                                  : $urandom_range(0, 20);
                add_message(len, 1'b0);
                pending_requests.push_back(make_req(sha256_pkg::OP_FINISH,
                                           8'($urandom_range(0, 255))));
                n += len + 1;
            end
            else if (pick < 93)
            begin
                len = $urandom_range(0, 10);
                add_message(len, 1'b0);
                pending_requests.push_back(make_req(sha256_pkg::OP_RESTART,
                                           8'($urandom_range(0, 255))));
                n += len + 1;
            end
            else
            begin
                pending_requests.push_back(make_req(OP_UNUSED,
                                           8'($urandom_range(0, 255))));
                n += 1;
            end
            wait (pending_requests.size() < 64);
        end
        pending_requests.push_back(make_req(sha256_pkg::OP_FINISH, 8'h00));
        wait (pending_requests.size() == 0 && expected_digest_words.size() == 0);
        repeat (300) @(posedge clk);

        if (mismatch_count == 0 && expected_digest_words.size() == 0)
            $display("tb_sha256_stream_hasher_unit OK");
        else
            $display("tb_sha256_stream_hasher_unit NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
